>>> sv/assert_macros.svh
// Assertion helpers for the store write buffer. Both expect signals named clk and rst
// in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// When the first condition holds, the second must hold in the following cycle.
`define SWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/swb_pkg.sv
`default_nettype none
package swb_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic [4:0] CAPACITY_RESET  = 5'd16;
  localparam logic [3:0] LINE_BITS_RESET = 4'd6;
  localparam logic [4:0] MAX_ISSUE       = 5'd16;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_ISSUE    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;
  localparam logic [1:0] OP_LOAD     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_MQ_MATCH  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_LINE_BITS = 1'b1;

  // One buffered store as kept in the entry memory.
  typedef struct packed {
    logic [63:0] line;
    logic [63:0] logical;
    logic [63:0] pc;
    logic        priv;
    logic [2:0]  thread;
  } swb_entry_t;

endpackage
`default_nettype wire

>>> sv/swb_entry_ram.sv
`default_nettype none
module swb_entry_ram #(
  parameter int DEPTH = swb_pkg::DEPTH_DEFAULT,
  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [SW-1:0]      waddr,
  input  wire swb_pkg::swb_entry_t wdata,
  input  wire logic               re,
  input  wire logic [SW-1:0]      raddr,
  output      swb_pkg::swb_entry_t rdata
);
  import swb_pkg::*;

  swb_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/store_write_buffer_top.sv
// Store write buffer. Retired stores are held in up to min(capacity, DEPTH) slots, with
// their payload (line, logical address, pc, privilege, thread) in a single-port-read
// entry memory and the age, valid and outstanding marks in flip-flops. An add item is
// answered without a walk: the lowest free slot is taken and the front end is stalled
// when the buffer is full. Issue, completion and load-check items walk the entries
// oldest first, one entry at a time (slot lookup by age and memory read, then compare
// or send, which waits while the output register is held); an issue item skips entries
// already outstanding without reading them and yields one result per issued entry, the
// last one flagged. Completion frees the oldest entry matching line and thread and
// releases the stall. Results sit in an output register, and a new item is taken only
// when the walk of the previous one is done and that register is free or being drained.
// Configuration writes are always taken.
`default_nettype none
module store_write_buffer_top #(
  parameter int DEPTH = swb_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] phys_addr,
  input  wire logic [63:0] logical_addr,
  input  wire logic [63:0] pc_value,
  input  wire logic        privileged,
  input  wire logic [2:0]  thread_id,
  input  wire logic        completion_is_store,
  input  wire logic        miss_queue_hit,
  input  wire logic        miss_queue_busy,
  input  wire logic [4:0]  ready_count,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  kind,
  output      logic [1:0]  status,
  output      logic [3:0]  slot,
  output      logic        hit,
  output      logic [63:0] line_addr,
  output      logic [63:0] out_logical_addr,
  output      logic [63:0] out_pc,
  output      logic        out_privileged,
  output      logic [2:0]  out_thread,
  output      logic        fetch_stall,
  output      logic        last
);
  import swb_pkg::*;

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state;

  logic [4:0] capacity;
  logic [3:0] line_bits;

  logic [DEPTH-1:0] entry_valid;
  logic [DEPTH-1:0] entry_outstanding;
  logic [SW-1:0]    entry_age [DEPTH];
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    outstanding_count;
  logic             full_stalled;

  // Latched item being walked.
  logic [1:0]    op_q;
  logic [63:0]   line_q;
  logic [2:0]    thread_q;
  logic [4:0]    budget_q;
  logic [4:0]    issued;
  logic [SW-1:0] age_k;
  logic [SW-1:0] cur_slot;

  logic [63:0]   line_in;
  logic [SW-1:0] sel_slot;
  logic [SW-1:0] free_slot;
  logic          free_found;
  logic          later_elig;
  logic          cap_full;
  logic          cap_zero;
  logic          can_load;
  logic          accept;
  logic          last_k;
  logic          add_ok;
  logic [4:0]    budget_in;
  logic          ram_re;
  swb_entry_t    ram_wdata;
  swb_entry_t    ram_rdata;
  logic          issue_last;
  logic          line_match;
  logic          comp_match;

  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && can_load;
  assign accept    = in_valid && in_ready;

  assign line_in  = phys_addr & ~((64'd1 << line_bits) - 64'd1);
  assign cap_zero = (capacity == 5'd0);
  assign cap_full = 32'(entry_count) >=
                    ((32'(capacity) > DEPTH) ? DEPTH : 32'(capacity));
  assign add_ok   = !miss_queue_hit && !cap_zero && !cap_full && free_found;
  assign budget_in = (ready_count > MAX_ISSUE) ? MAX_ISSUE : ready_count;
  assign last_k   = (CW'(age_k) + CW'(1)) == entry_count;

  // Ages of valid entries are dense, so exactly one slot carries the age being visited.
  always_comb begin
    sel_slot   = '0;
    free_slot  = '0;
    free_found = 1'b0;
    later_elig = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_age[i] == age_k) begin
        sel_slot = SW'(i);
      end
      if (!entry_valid[i]) begin
        free_slot  = SW'(i);
        free_found = 1'b1;
      end
      if (entry_valid[i] && !entry_outstanding[i] && entry_age[i] > age_k) begin
        later_elig = 1'b1;
      end
    end
  end

  assign ram_re = (state == S_SCAN) &&
                  !(op_q == OP_ISSUE && entry_outstanding[sel_slot]);
  assign ram_wdata = '{line: line_in, logical: logical_addr, pc: pc_value,
                       priv: privileged, thread: thread_id};

  swb_entry_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (accept && op == OP_ADD && add_ok),
    .waddr (free_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (sel_slot),
    .rdata (ram_rdata)
  );

  assign line_match = (ram_rdata.line == line_q);
  assign comp_match = line_match && (ram_rdata.thread == thread_q);
  assign issue_last = ((issued + 5'd1) == budget_q) || !later_elig;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      entry_valid       <= '0;
      entry_outstanding <= '0;
      entry_count       <= '0;
      outstanding_count <= '0;
      full_stalled      <= 1'b0;
      capacity          <= CAPACITY_RESET;
      line_bits         <= LINE_BITS_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index[0])
          REG_CAPACITY:  capacity  <= cfg_data;
          REG_LINE_BITS: line_bits <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op;
            line_q   <= line_in;
            thread_q <= thread_id;
            budget_q <= budget_in;
            issued   <= '0;
            age_k    <= '0;
            kind             <= op;
            status           <= ST_OK;
            slot             <= '0;
            hit              <= 1'b0;
            line_addr        <= '0;
            out_logical_addr <= '0;
            out_pc           <= '0;
            out_privileged   <= 1'b0;
            out_thread       <= '0;
            fetch_stall      <= full_stalled;
            last             <= 1'b1;
            unique case (op)
              OP_ADD: begin
                out_valid <= 1'b1;
                if (miss_queue_hit) begin
                  status <= ST_MQ_MATCH;
                end else if (cap_zero) begin
                  status <= ST_OK;
                end else if (!add_ok) begin
                  status       <= ST_FULL;
                  full_stalled <= 1'b1;
                  fetch_stall  <= 1'b1;
                end else begin
                  entry_valid[free_slot]       <= 1'b1;
                  entry_outstanding[free_slot] <= 1'b0;
                  entry_age[free_slot]         <= SW'(entry_count);
                  entry_count                  <= entry_count + CW'(1);
                  slot                         <= 4'(free_slot);
                end
              end
              OP_ISSUE: begin
                if (!cap_zero && !miss_queue_busy && budget_in != 5'd0 &&
                    entry_count != '0) begin
                  state <= S_SCAN;
                end
              end
              OP_COMPLETE: begin
                if (cap_zero) begin
                  out_valid <= 1'b1;
                end else if (!completion_is_store || entry_count == '0) begin
                  out_valid <= 1'b1;
                  status    <= ST_NOT_FOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_LOAD: begin
                if (entry_count == '0) begin
                  out_valid <= 1'b1;
                  status    <= ST_NOT_FOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (op_q == OP_ISSUE && entry_outstanding[sel_slot]) begin
            if (last_k) begin
              state <= S_IDLE;
            end else begin
              age_k <= age_k + SW'(1);
            end
          end else begin
            cur_slot <= sel_slot;
            state    <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (can_load) begin
            kind             <= op_q;
            status           <= ST_OK;
            slot             <= '0;
            hit              <= 1'b0;
            line_addr        <= '0;
            out_logical_addr <= '0;
            out_pc           <= '0;
            out_privileged   <= 1'b0;
            out_thread       <= '0;
            fetch_stall      <= full_stalled;
            last             <= 1'b1;
            if (op_q == OP_ISSUE) begin
              out_valid                   <= 1'b1;
              slot                        <= 4'(cur_slot);
              line_addr                   <= ram_rdata.line;
              out_logical_addr            <= ram_rdata.logical;
              out_pc                      <= ram_rdata.pc;
              out_privileged              <= ram_rdata.priv;
              out_thread                  <= ram_rdata.thread;
              last                        <= issue_last;
              entry_outstanding[cur_slot] <= 1'b1;
              outstanding_count           <= outstanding_count + CW'(1);
              issued                      <= issued + 5'd1;
              if (issue_last) begin
                state <= S_IDLE;
              end else begin
                age_k <= age_k + SW'(1);
                state <= S_SCAN;
              end
            end else if ((op_q == OP_COMPLETE) ? comp_match : line_match) begin
              out_valid <= 1'b1;
              slot      <= 4'(cur_slot);
              state     <= S_IDLE;
              if (op_q == OP_LOAD) begin
                hit <= 1'b1;
              end else begin
                // Free the entry and close the gap in the age order behind it.
                for (int i = 0; i < DEPTH; i++) begin
                  if (entry_valid[i] && entry_age[i] > age_k) begin
                    entry_age[i] <= entry_age[i] - SW'(1);
                  end
                end
                entry_valid[cur_slot]       <= 1'b0;
                entry_outstanding[cur_slot] <= 1'b0;
                entry_count                 <= entry_count - CW'(1);
                if (entry_outstanding[cur_slot]) begin
                  outstanding_count <= outstanding_count - CW'(1);
                end
                full_stalled <= 1'b0;
                fetch_stall  <= 1'b0;
              end
            end else if (last_k) begin
              out_valid <= 1'b1;
              status    <= ST_NOT_FOUND;
              state     <= S_IDLE;
            end else begin
              age_k <= age_k + SW'(1);
              state <= S_SCAN;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `SWB_ASSERT(a_count_matches_valid, CW'($countones(entry_valid)) == entry_count, "entry count disagrees with valid slots")
  `SWB_ASSERT(a_outstanding_bound, CW'($countones(entry_outstanding)) <= entry_count, "more outstanding entries than entries")
  `SWB_ASSERT(a_outstanding_count, CW'($countones(entry_outstanding)) == outstanding_count, "outstanding count disagrees with marks")
  `SWB_ASSERT(a_outstanding_valid, (entry_outstanding & ~entry_valid) == '0, "outstanding mark on a free slot")
  `SWB_ASSERT_NEXT(a_add_grows, accept && op == OP_ADD && add_ok, entry_count == $past(entry_count) + CW'(1), "add did not take a slot")

endmodule
`default_nettype wire
